[design/rvc_pkg.sv]
`timescale 1ns / 1ps

package rvc_pkg;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_LOAD  = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NOP   = 2'd3
    } rvc_cmd_t;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_RANGE  = 2'd1;
    localparam logic [1:0] ST_TARGET = 2'd2;

    localparam logic [6:0] OP_REG    = 7'h33;
    localparam logic [6:0] OP_IMM    = 7'h13;
    localparam logic [6:0] OP_LOAD   = 7'h03;
    localparam logic [6:0] OP_STORE  = 7'h23;
    localparam logic [6:0] OP_LUI    = 7'h37;
    localparam logic [6:0] OP_JALR   = 7'h67;
    localparam logic [6:0] OP_BRANCH = 7'h63;
    localparam logic [6:0] OP_JAL    = 7'h6F;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] instr_word;
        logic [9:0]  read_index;
    } rvc_in_t;

    typedef struct packed {
        logic [31:0] out_word;
        logic        is_compressed;
        logic [1:0]  status;
    } rvc_out_t;

    typedef struct packed {
        rvc_cmd_t    cmd;
        logic [31:0] word;
        logic [9:0]  index;
        logic        comp;
    } rvc_entry_t;

    typedef struct packed {
        logic        ok;
        logic [15:0] enc;
    } rvc_class_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_FETCH,
        BK_TARGET
    } rvc_bk_state_t;

    function automatic logic common_reg(input logic [4:0] r);
        return r[4:3] == 2'b01;
    endfunction

    // Compressibility check and fixed 16-bit encoding of one RV32I word.
    function automatic rvc_class_t classify(input logic [31:0] w);
        rvc_class_t  res;
        logic [6:0]  op;
        logic [4:0]  rd;
        logic [2:0]  f3;
        logic [4:0]  rs1;
        logic [4:0]  rs2;
        logic [6:0]  f7;
        logic        imm_fits;
        logic        imm_zero;
        logic [1:0]  f2;
        logic        alu_hit;
        logic [11:0] mimm;
        logic [4:0]  low;
        op       = w[6:0];
        rd       = w[11:7];
        f3       = w[14:12];
        rs1      = w[19:15];
        rs2      = w[24:20];
        f7       = w[31:25];
        imm_fits = (w[31:25] == 7'h00) || (w[31:25] == 7'h7F);
        imm_zero = (w[31:20] == 12'h000);
        res      = '0;
        f2       = 2'd0;
        alu_hit  = 1'b0;
        mimm     = '0;
        low      = '0;
        case (op)
            OP_REG: begin
                if (f3 == 3'd0 && f7 == 7'h00) begin
                    if (rd == rs1) begin
                        if (rd != 5'd0 && rs2 != 5'd0) begin
                            res.ok  = 1'b1;
                            res.enc = {4'b1001, rd, rs2, 2'b10};
                        end
                    end else if (rs1 == 5'd0) begin
                        if (rd != 5'd0 && rs2 != 5'd0) begin
                            res.ok  = 1'b1;
                            res.enc = {4'b1000, rd, rs2, 2'b10};
                        end
                    end
                end else begin
                    if (f3 == 3'd0 && f7 == 7'h20) begin
                        f2 = 2'd0; alu_hit = 1'b1;
                    end else if (f3 == 3'd4 && f7 == 7'h00) begin
                        f2 = 2'd1; alu_hit = 1'b1;
                    end else if (f3 == 3'd6 && f7 == 7'h00) begin
                        f2 = 2'd2; alu_hit = 1'b1;
                    end else if (f3 == 3'd7 && f7 == 7'h00) begin
                        f2 = 2'd3; alu_hit = 1'b1;
                    end
                    if (alu_hit && common_reg(rd) && common_reg(rs1) && common_reg(rs2)
                            && rd == rs1) begin
                        res.ok  = 1'b1;
                        res.enc = {6'b100011, rd[2:0], f2, rs2[2:0], 2'b01};
                    end
                end
            end
            OP_IMM: begin
                if (f3 == 3'd0) begin
                    if (rd != 5'd0 && rs1 == 5'd0 && imm_fits) begin
                        res.ok  = 1'b1;
                        res.enc = {3'b010, w[25], rd, w[24:20], 2'b01};
                    end else if (rd == rs1 && imm_fits && !imm_zero && rd != 5'd0) begin
                        res.ok  = 1'b1;
                        res.enc = {3'b000, w[25], rd, w[24:20], 2'b01};
                    end
                end else if (f3 == 3'd1) begin
                    if (f7 == 7'h00 && rd == rs1 && rd != 5'd0) begin
                        res.ok  = 1'b1;
                        res.enc = {4'b0000, rd, w[24:20], 2'b10};
                    end
                end else if (f3 == 3'd5) begin
                    if ((f7 == 7'h00 || f7 == 7'h20) && rd == rs1 && common_reg(rs1)) begin
                        res.ok  = 1'b1;
                        res.enc = {3'b100, 1'b0, 1'b0, f7[5], rd[2:0], w[24:20], 2'b01};
                    end
                end else if (f3 == 3'd7) begin
                    if (rd == rs1 && common_reg(rs1) && imm_fits) begin
                        res.ok  = 1'b1;
                        res.enc = {3'b100, w[25], 2'b10, rd[2:0], w[24:20], 2'b01};
                    end
                end
            end
            OP_LOAD, OP_STORE: begin
                mimm = (op == OP_LOAD) ? w[31:20] : {w[31:25], w[11:7]};
                low  = (op == OP_LOAD) ? rd : rs2;
                if (f3 == 3'd2 && common_reg(rs1) && common_reg(low)
                        && mimm[11:7] == 5'd0 && mimm[1:0] == 2'd0) begin
                    res.ok  = 1'b1;
                    res.enc = {(op == OP_LOAD) ? 3'b010 : 3'b110, mimm[5:3], rs1[2:0],
                               mimm[2], mimm[6], low[2:0], 2'b00};
                end
            end
            OP_LUI: begin
                if (rd != 5'd0 && rd != 5'd2 && w[31:12] != 20'd0
                        && (w[31:17] == 15'h0000 || w[31:17] == 15'h7FFF)) begin
                    res.ok  = 1'b1;
                    res.enc = {3'b011, w[17], rd, w[16:12], 2'b01};
                end
            end
            OP_JALR: begin
                if (f3 == 3'd0 && rs1 != 5'd0 && imm_zero && (rd == 5'd0 || rd == 5'd1)) begin
                    res.ok  = 1'b1;
                    res.enc = {(rd == 5'd0) ? 4'b1000 : 4'b1001, rs1, 5'd0, 2'b10};
                end
            end
            OP_BRANCH: begin
                res.ok = (f3 == 3'd0 || f3 == 3'd1) && common_reg(rs1) && rs2 == 5'd0;
            end
            OP_JAL: begin
                res.ok = (rd == 5'd0 || rd == 5'd1);
            end
            default: begin
                res = '0;
            end
        endcase
        return res;
    endfunction

endpackage

[design/rvc_front.sv]
`timescale 1ns / 1ps

module rvc_front
    import rvc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  rvc_in_t    s_data,
    input  logic       q_full,
    output logic       push,
    output rvc_entry_t push_entry
);

    rvc_class_t cls;
    logic       seen_reg;

    // Held low through reset so nothing is taken before the queue is cleared.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg <= 1'b0;
        end else begin
            seen_reg <= 1'b1;
        end
    end

    assign cls     = classify(s_data.instr_word);
    assign s_ready = seen_reg && !q_full;

    // The unused command is taken and dropped here.
    assign push = s_valid && s_ready && (rvc_cmd_t'(s_data.command) != CMD_NOP);

    always_comb begin
        push_entry.cmd   = rvc_cmd_t'(s_data.command);
        push_entry.word  = s_data.instr_word;
        push_entry.index = s_data.read_index;
        push_entry.comp  = cls.ok;
    end

endmodule

[design/rvc_queue.sv]
`timescale 1ns / 1ps

module rvc_queue
    import rvc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  rvc_entry_t push_entry,
    output logic       full,
    input  logic       pop,
    output logic       head_valid,
    output rvc_entry_t head
);

    rvc_entry_t slot_reg [2];
    logic       wptr_reg;
    logic       rptr_reg;
    logic [1:0] fill_reg;

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            fill_reg <= 2'd0;
        end else begin
            if (push) begin
                wptr_reg <= !wptr_reg;
            end
            if (pop) begin
                rptr_reg <= !rptr_reg;
            end
            if (push && !pop) begin
                fill_reg <= fill_reg + 2'd1;
            end else if (pop && !push) begin
                fill_reg <= fill_reg - 2'd1;
            end
        end
    end

    assign full       = (fill_reg == 2'd2);
    assign head_valid = (fill_reg != 2'd0);
    assign head       = slot_reg[rptr_reg];

endmodule

[design/rvc_back.sv]
`timescale 1ns / 1ps

module rvc_back
    import rvc_pkg::*;
#(
    parameter int PROG_DEPTH = 1024
)(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       head_valid,
    input  rvc_entry_t head,
    output logic       pop,
    output logic       m_valid,
    input  logic       m_ready,
    output rvc_out_t   m_data
);

    localparam int AW   = (PROG_DEPTH > 1) ? $clog2(PROG_DEPTH) : 1;
    localparam int CW   = $clog2(PROG_DEPTH + 1);
    localparam int SUMW = $clog2(4 * PROG_DEPTH + 1);
    localparam int XW   = (CW > 10) ? CW : 10;
    localparam int TW   = ((XW > 19) ? XW : 19) + 2;

    logic [31:0]     prog_mem [PROG_DEPTH];
    logic            mark_mem [PROG_DEPTH];
    logic [SUMW-1:0] sum_mem  [PROG_DEPTH + 1];

    rvc_bk_state_t   state_reg, state_next;
    logic [CW-1:0]   count_reg;
    logic [SUMW-1:0] last_sum_reg;
    logic [31:0]     word_rd_reg;
    logic            mark_rd_reg;
    logic [SUMW-1:0] sum_rd_reg;
    logic            sum_zero_reg;
    logic [9:0]      idx_reg;
    logic [SUMW-1:0] sumi_reg;
    logic            out_valid_reg;
    rvc_out_t        out_reg;

    logic            do_clear, do_load, start_read, issue_tgt, out_load;
    rvc_out_t        out_next;
    logic [CW-1:0]   sum_addr;
    logic            sum_rd_en;

    logic [SUMW-1:0] sum_val;
    logic            over;
    logic            is_branch, is_jal;
    logic [20:0]     off;
    logic [18:0]     lines;
    logic [TW-1:0]   tgt;
    logic            tgt_bad;
    rvc_class_t      cls;
    logic [SUMW:0]   diff;
    logic [20:0]     u;
    logic [31:0]     jump_word;

    assign sum_val   = sum_zero_reg ? '0 : sum_rd_reg;
    assign over      = XW'(idx_reg) >= XW'(count_reg);
    assign is_branch = (word_rd_reg[6:0] == OP_BRANCH);
    assign is_jal    = (word_rd_reg[6:0] == OP_JAL);
    assign cls       = classify(word_rd_reg);

    // Original byte offset turned into a line count, rounded toward zero.
    always_comb begin
        if (is_branch) begin
            off = 21'(signed'({word_rd_reg[31], word_rd_reg[7], word_rd_reg[30:25],
                               word_rd_reg[11:8], 1'b0}));
        end else begin
            off = {word_rd_reg[31], word_rd_reg[19:12], word_rd_reg[20],
                   word_rd_reg[30:21], 1'b0};
        end
        lines = off[20:2] + {18'd0, off[20] && off[1]};
        tgt   = TW'(signed'({1'b0, idx_reg})) + TW'(signed'(lines));
        tgt_bad = tgt[TW-1] || (signed'(tgt) > signed'(TW'(count_reg)));
    end

    // Relocated offset, sign-extended from the address-sum difference.
    always_comb begin
        diff = {1'b0, sum_val} - {1'b0, sumi_reg};
        u    = 21'(signed'(diff));
        if (is_branch) begin
            if (mark_rd_reg) begin
                jump_word = {16'd0, (word_rd_reg[14:12] == 3'd0) ? 3'b110 : 3'b111, u[8],
                             u[4:3], word_rd_reg[17:15], u[7:6], u[2:1], u[5], 2'b01};
            end else begin
                jump_word = {u[12], u[10:5], word_rd_reg[24:12], u[4:1], u[11],
                             word_rd_reg[6:0]};
            end
        end else begin
            if (mark_rd_reg) begin
                jump_word = {16'd0, (word_rd_reg[11:7] == 5'd0) ? 3'b101 : 3'b001, u[11],
                             u[4], u[9:8], u[10], u[6], u[7], u[3:1], u[5], 2'b01};
            end else begin
                jump_word = {u[20], u[10:1], u[11], u[19:12], word_rd_reg[11:0]};
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE: begin
                if (start_read) begin
                    state_next = BK_FETCH;
                end
            end
            BK_FETCH: begin
                if (issue_tgt) begin
                    state_next = BK_TARGET;
                end else begin
                    state_next = BK_IDLE;
                end
            end
            BK_TARGET: begin
                state_next = BK_IDLE;
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb begin
        pop        = 1'b0;
        do_clear   = 1'b0;
        do_load    = 1'b0;
        start_read = 1'b0;
        issue_tgt  = 1'b0;
        out_load   = 1'b0;
        out_next   = '0;
        sum_rd_en  = 1'b0;
        sum_addr   = CW'(idx_reg);
        case (state_reg)
            BK_IDLE: begin
                if (head_valid) begin
                    case (head.cmd)
                        CMD_CLEAR: begin
                            pop      = 1'b1;
                            do_clear = 1'b1;
                        end
                        CMD_LOAD: begin
                            pop     = 1'b1;
                            do_load = count_reg < CW'(PROG_DEPTH);
                        end
                        CMD_READ: begin
                            // A new read waits until the previous result is taken.
                            if (!out_valid_reg) begin
                                pop        = 1'b1;
                                start_read = 1'b1;
                                sum_rd_en  = 1'b1;
                                sum_addr   = CW'(head.index);
                            end
                        end
                        default: begin
                            pop = 1'b1;
                        end
                    endcase
                end
            end
            BK_FETCH: begin
                if (over) begin
                    out_load = 1'b1;
                    out_next = '{out_word: 32'd0, is_compressed: 1'b0, status: ST_RANGE};
                end else if (is_branch || is_jal) begin
                    if (tgt_bad) begin
                        out_load = 1'b1;
                        out_next = '{out_word: 32'd0, is_compressed: mark_rd_reg,
                                     status: ST_TARGET};
                    end else begin
                        issue_tgt = 1'b1;
                        sum_rd_en = 1'b1;
                        sum_addr  = CW'(tgt);
                    end
                end else begin
                    out_load = 1'b1;
                    out_next = '{out_word: (mark_rd_reg && cls.ok) ? {16'd0, cls.enc}
                                                                   : word_rd_reg,
                                 is_compressed: mark_rd_reg, status: ST_OK};
                end
            end
            BK_TARGET: begin
                out_load = 1'b1;
                out_next = '{out_word: jump_word, is_compressed: mark_rd_reg, status: ST_OK};
            end
            default: begin
                pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (do_load) begin
            prog_mem[AW'(count_reg)]  <= head.word;
            mark_mem[AW'(count_reg)]  <= head.comp;
            sum_mem[count_reg + CW'(1)] <= last_sum_reg + (head.comp ? SUMW'(2) : SUMW'(4));
        end
        if (start_read) begin
            word_rd_reg <= prog_mem[AW'(head.index)];
            mark_rd_reg <= mark_mem[AW'(head.index)];
            idx_reg     <= head.index;
        end
        if (sum_rd_en) begin
            sum_rd_reg   <= sum_mem[sum_addr];
            sum_zero_reg <= (sum_addr == '0);
        end
        if (issue_tgt) begin
            sumi_reg <= sum_val;
        end
        if (out_load) begin
            out_reg <= out_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_IDLE;
            count_reg     <= '0;
            last_sum_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (do_clear) begin
                count_reg    <= '0;
                last_sum_reg <= '0;
            end else if (do_load) begin
                count_reg    <= count_reg + CW'(1);
                last_sum_reg <= last_sum_reg + (head.comp ? SUMW'(2) : SUMW'(4));
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

[design/rv32i_to_rvc_compressor.sv]
`timescale 1ns / 1ps

// RV32I to RVC compressor. Requests carry a command: clear, load one 32-bit word, or read
// the converted instruction at an index; only a read returns a result. A front stage
// classifies each word as it arrives and hands requests through a two-entry queue to the
// execution side, so new requests are taken while a result waits at the output register.
// Clear and load are handled in the idle state. A read passes through a fetch state and,
// for a branch or jal with an in-range target, a target state, as the address-sum memory
// has one read port and is read first at the index and then at the branch target; the
// result then sits in the output register until taken, and the next read starts once it
// is gone. The stores need no clearing after reset: address-sum entry zero reads as zero.
module rv32i_to_rvc_compressor
    import rvc_pkg::*;
#(
    parameter int PROG_DEPTH = 1024
)(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  rvc_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output rvc_out_t m_data
);

    logic       q_full;
    logic       push;
    rvc_entry_t push_entry;
    logic       pop;
    logic       head_valid;
    rvc_entry_t head;

    rvc_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .q_full     (q_full),
        .push       (push),
        .push_entry (push_entry)
    );

    rvc_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    rvc_back #(
        .PROG_DEPTH (PROG_DEPTH)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> head_valid) else $error("queue popped while empty");

    a_range_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status == ST_RANGE) |-> (m_data.out_word == 32'd0
            && !m_data.is_compressed)) else $error("index error result not cleared");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.status != 2'd3)) else $error("undefined status code");

    a_compressed_high: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.is_compressed && m_data.status == ST_OK)
            |-> (m_data.out_word[31:16] == 16'd0)) else $error("compressed word too wide");

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import rvc_pkg::*;

    localparam int DEPTH      = 1024;
    localparam int IDLE_LIMIT = 5000;

    logic     aclk = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    rvc_in_t  s_data = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    rvc_out_t m_data;

    always #2 aclk = ~aclk;

    rv32i_to_rvc_compressor #(.PROG_DEPTH(DEPTH)) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Shadow of the program memory, size marks and compressed address sums.
    logic [31:0] prog_words [DEPTH];
    logic        prog_short [DEPTH];
    logic [31:0] addr_sums [DEPTH+1];
    int          prog_len;

    rvc_out_t expected_q [$];
    int       mismatches;
    int       reads_sent;
    int       short_reads;
    int       target_errs;
    bit       idle_en;
    int       stall_left;
    int       quiet_cycles;

    function automatic bit is_creg(input logic [4:0] r);
        return r >= 5'd8 && r <= 5'd15;
    endfunction

    // Decides whether a word has a 16-bit form and builds the fixed encoding.
    function automatic bit rvc_form(input logic [31:0] w, output logic [15:0] enc);
        logic [6:0]  op;
        logic [4:0]  rd, rs1, rs2, sh;
        logic [2:0]  f3;
        logic [6:0]  f7;
        int          immi, imm;
        logic [5:0]  u6;
        logic [6:0]  um;
        logic [1:0]  f2;
        logic [4:0]  low;
        op = w[6:0]; rd = w[11:7]; f3 = w[14:12]; rs1 = w[19:15]; rs2 = w[24:20];
        f7 = w[31:25]; sh = w[24:20];
        immi = int'($signed(w[31:20]));
        u6 = immi[5:0];
        enc = '0;
        case (op)
            OP_REG: begin
                if (f3 == 3'd0 && f7 == 7'h00) begin
                    if (rd == rs1) begin
                        if (rd != 0 && rs2 != 0) begin
                            enc = {4'h9, rd, rs2, 2'b10};
                            return 1'b1;
                        end
                    end else if (rs1 == 0 && rd != 0 && rs2 != 0) begin
                        enc = {4'h8, rd, rs2, 2'b10};
                        return 1'b1;
                    end
                    return 1'b0;
                end
                if (f3 == 3'd0 && f7 == 7'h20) f2 = 2'd0;
                else if (f3 == 3'd4 && f7 == 7'h00) f2 = 2'd1;
                else if (f3 == 3'd6 && f7 == 7'h00) f2 = 2'd2;
                else if (f3 == 3'd7 && f7 == 7'h00) f2 = 2'd3;
                else return 1'b0;
                if (is_creg(rd) && is_creg(rs2) && rd == rs1) begin
                    enc = {6'b100011, rd[2:0], f2, rs2[2:0], 2'b01};
                    return 1'b1;
                end
                return 1'b0;
            end
            OP_IMM: begin
                if (f3 == 3'd0) begin
                    if (rd != 0 && rs1 == 0 && immi >= -32 && immi <= 31) begin
                        enc = {3'b010, u6[5], rd, u6[4:0], 2'b01};
                        return 1'b1;
                    end
                    if (rd == rs1 && rd != 0 && immi != 0 && immi >= -32 && immi <= 31) begin
                        enc = {3'b000, u6[5], rd, u6[4:0], 2'b01};
                        return 1'b1;
                    end
                    return 1'b0;
                end
                if (f3 == 3'd1 && f7 == 7'h00) begin
                    if (rd == rs1 && rd != 0) begin
                        enc = {4'b0000, rd, sh, 2'b10};
                        return 1'b1;
                    end
                    return 1'b0;
                end
                if (f3 == 3'd5 && (f7 == 7'h00 || f7 == 7'h20)) begin
                    if (rd == rs1 && is_creg(rs1)) begin
                        enc = {3'b100, 2'b00, f7[5], rd[2:0], sh, 2'b01};
                        return 1'b1;
                    end
                    return 1'b0;
                end
                if (f3 == 3'd7 && rd == rs1 && is_creg(rs1) && immi >= -32 && immi <= 31) begin
                    enc = {3'b100, u6[5], 2'b10, rd[2:0], u6[4:0], 2'b01};
                    return 1'b1;
                end
                return 1'b0;
            end
            OP_LOAD, OP_STORE: begin
                if (f3 != 3'd2) return 1'b0;
                imm = (op == OP_LOAD) ? immi : int'($signed({w[31:25], w[11:7]}));
                low = (op == OP_LOAD) ? rd : rs2;
                if (!(is_creg(rs1) && is_creg(low) && imm >= 0 && imm <= 127 && imm % 4 == 0))
                    return 1'b0;
                um = imm[6:0];
                enc = {(op == OP_LOAD) ? 3'b010 : 3'b110, um[5:3], rs1[2:0], um[2], um[6],
                       low[2:0], 2'b00};
                return 1'b1;
            end
            OP_LUI: begin
                imm = int'($signed(w[31:12]));
                u6 = imm[5:0];
                if (rd != 0 && rd != 2 && imm != 0 && imm >= -32 && imm <= 31) begin
                    enc = {3'b011, u6[5], rd, u6[4:0], 2'b01};
                    return 1'b1;
                end
                return 1'b0;
            end
            OP_JALR: begin
                if (f3 == 3'd0 && rs1 != 0 && immi == 0 && (rd == 0 || rd == 1)) begin
                    enc = {(rd == 0) ? 4'h8 : 4'h9, rs1, 5'd0, 2'b10};
                    return 1'b1;
                end
                return 1'b0;
            end
            OP_BRANCH: return (f3 == 3'd0 || f3 == 3'd1) && is_creg(rs1) && rs2 == 0;
            OP_JAL:    return rd == 0 || rd == 1;
            default:   return 1'b0;
        endcase
    endfunction

    // Applies one accepted request to the shadow state and queues any expected result.
    task automatic apply_request(input rvc_in_t d);
        rvc_out_t    r;
        logic [31:0] w, u;
        logic [15:0] enc;
        bit          c;
        int          off, tgt, i;
        case (rvc_cmd_t'(d.command))
            CMD_CLEAR: prog_len = 0;
            CMD_LOAD: begin
                if (prog_len < DEPTH) begin
                    c = rvc_form(d.instr_word, enc);
                    prog_words[prog_len] = d.instr_word;
                    prog_short[prog_len] = c;
                    addr_sums[prog_len+1] = addr_sums[prog_len] + (c ? 32'd2 : 32'd4);
                    prog_len++;
                end
            end
            CMD_READ: begin
                i = int'(d.read_index);
                reads_sent++;
                r = '0;
                if (i >= prog_len) begin
                    r.status = ST_RANGE;
                end else begin
                    w = prog_words[i];
                    c = prog_short[i];
                    r.is_compressed = c;
                    r.status = ST_OK;
                    if (w[6:0] == OP_BRANCH || w[6:0] == OP_JAL) begin
                        if (w[6:0] == OP_BRANCH)
                            off = int'($signed({w[31], w[7], w[30:25], w[11:8], 1'b0}));
                        else
                            off = int'($signed({w[31], w[19:12], w[20], w[30:21], 1'b0}));
                        tgt = i + off / 4;
                        if (tgt < 0 || tgt > prog_len) begin
                            r.status = ST_TARGET;
                            target_errs++;
                        end else begin
                            u = addr_sums[tgt] - addr_sums[i];
                            if (w[6:0] == OP_BRANCH && c)
                                r.out_word = {16'd0, (w[14:12] == 3'd0) ? 3'b110 : 3'b111,
                                              u[8], u[4:3], w[17:15], u[7:6], u[2:1], u[5],
                                              2'b01};
                            else if (w[6:0] == OP_BRANCH)
                                r.out_word = {u[12], u[10:5], w[24:12], u[4:1], u[11], w[6:0]};
                            else if (c)
                                r.out_word = {16'd0, (w[11:7] == 5'd0) ? 3'b101 : 3'b001,
                                              u[11], u[4], u[9:8], u[10], u[6], u[7], u[3:1],
                                              u[5], 2'b01};
                            else
                                r.out_word = {u[20], u[10:1], u[11], u[19:12], w[11:0]};
                        end
                    end else if (c && rvc_form(w, enc)) begin
                        r.out_word = {16'd0, enc};
                    end else begin
                        r.out_word = w;
                    end
                    if (c) short_reads++;
                end
                expected_q.push_back(r);
            end
            default: ;
        endcase
    endtask

    // Sends one request, with an occasional idle burst in front of it.
    task automatic send_request(input rvc_in_t d);
        if (idle_en && $urandom_range(0, 7) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= d;
        do @(posedge aclk); while (!s_ready);
        apply_request(d);
    endtask

    task automatic send_cmd(input rvc_cmd_t c, input logic [31:0] w, input logic [9:0] idx);
        rvc_in_t d;
        d.command    = c;
        d.instr_word = w;
        d.read_index = idx;
        send_request(d);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (expected_q.size() != 0);
    endtask

    function automatic logic [31:0] branch_word(input int off, input logic [2:0] f3,
                                                input logic [4:0] rs1, input logic [4:0] rs2);
        logic [12:0] o;
        o = 13'(off);
        return {o[12], o[10:5], rs2, rs1, f3, o[4:1], o[11], OP_BRANCH};
    endfunction

    function automatic logic [31:0] jal_word(input int off, input logic [4:0] rd);
        logic [20:0] o;
        o = 21'(off);
        return {o[20], o[10:1], o[11], o[19:12], rd, OP_JAL};
    endfunction

    // Mostly compressible shapes with random content, plus near misses and noise.
    function automatic logic [31:0] gen_word(input int span);
        logic [4:0]  rd, rs, cr, cr2;
        logic [11:0] imm;
        logic [31:0] w;
        int          off;
        rd  = 5'($urandom_range(0, 31));
        rs  = 5'($urandom_range(0, 31));
        cr  = 5'($urandom_range(8, 15));
        cr2 = 5'($urandom_range(8, 15));
        off = int'(($urandom_range(0, 2 * span) - span) * 4 + 2 * $urandom_range(0, 1));
        imm = 12'($urandom_range(0, 63) - 32);
        case ($urandom_range(0, 11))
            0:  w = {7'h00, rs, ($urandom_range(0, 1) ? rd : 5'd0), 3'd0, rd, OP_REG};
            1:  w = {($urandom_range(0, 3) == 0) ? 7'h20 : 7'h00, cr2, cr,
                     3'($urandom_range(4, 7)), cr, OP_REG};
            2:  w = {imm, ($urandom_range(0, 1) ? rd : 5'd0), 3'd0, rd, OP_IMM};
            3:  w = {($urandom_range(0, 1) ? 7'h20 : 7'h00), 5'($urandom),
                     cr, ($urandom_range(0, 1) ? 3'd5 : 3'd1), cr, OP_IMM};
            4:  w = {imm, cr, 3'd7, cr, OP_IMM};
            5:  begin
                imm = 12'($urandom_range(0, 31) * 4);
                if ($urandom_range(0, 1))
                    w = {imm, cr, 3'd2, cr2, OP_LOAD};
                else
                    w = {imm[11:5], cr2, cr, 3'd2, imm[4:0], OP_STORE};
            end
            6:  w = {{14{imm[5]}}, imm[5:0], rd, OP_LUI};
            7:  w = {12'd0, rs, 3'd0, 5'($urandom_range(0, 1)), OP_JALR};
            8, 9: w = branch_word(off, 3'($urandom_range(0, 1)), cr, 5'd0);
            10: w = jal_word(off, 5'($urandom_range(0, 1)));
            default: w = $urandom;
        endcase
        if ($urandom_range(0, 9) == 0) w[$urandom_range(7, 31)] ^= 1'b1;
        return w;
    endfunction

    task automatic test_directed();
        send_cmd(CMD_READ, 32'd0, 10'd0);
        send_cmd(CMD_NOP, 32'hFFFF_FFFF, 10'h3FF);
        send_cmd(CMD_LOAD, {7'h00, 5'd5, 5'd3, 3'd0, 5'd3, OP_REG}, '0);
        send_cmd(CMD_LOAD, {7'h20, 5'd9, 5'd8, 3'd0, 5'd8, OP_REG}, '0);
        send_cmd(CMD_LOAD, {12'hFE0, 5'd0, 3'd0, 5'd7, OP_IMM}, '0);
        send_cmd(CMD_LOAD, {7'h20, 5'd31, 5'd15, 3'd5, 5'd15, OP_IMM}, '0);
        send_cmd(CMD_LOAD, {12'h01F, 5'd12, 3'd7, 5'd12, OP_IMM}, '0);
        send_cmd(CMD_LOAD, {7'd3, 5'd9, 5'd8, 3'd2, 5'd28, OP_STORE}, '0);
        send_cmd(CMD_LOAD, {20'hFFFFF, 5'd4, OP_LUI}, '0);
        send_cmd(CMD_LOAD, {12'd0, 5'd1, 3'd0, 5'd1, OP_JALR}, '0);
        send_cmd(CMD_LOAD, branch_word(-8, 3'd1, 5'd8, 5'd0), '0);
        send_cmd(CMD_LOAD, jal_word(8, 5'd0), '0);
        send_cmd(CMD_LOAD, jal_word(-64, 5'd1), '0);
        send_cmd(CMD_LOAD, branch_word(8, 3'd4, 5'd3, 5'd4), '0);
        send_cmd(CMD_LOAD, 32'hFFFF_FFFF, '0);
        // The branch at index 11 lands exactly on the end of the program.
        for (int i = 0; i <= 13; i++) send_cmd(CMD_READ, 32'd0, 10'(i));
        send_cmd(CMD_READ, 32'd0, 10'h3FF);
        send_cmd(CMD_CLEAR, 32'd0, 10'd0);
        send_cmd(CMD_READ, 32'd0, 10'd0);
        wait_drained();
    endtask

    // Fills the whole program, checks that extra loads are dropped, then reads random entries and both ends.
    task automatic test_full_program();
        send_cmd(CMD_CLEAR, '0, '0);
        for (int i = 0; i < DEPTH + 4; i++) send_cmd(CMD_LOAD, gen_word(600), '0);
        for (int i = 0; i < 40; i++) send_cmd(CMD_READ, '0, 10'($urandom));
        send_cmd(CMD_READ, '0, 10'h3FF);
        send_cmd(CMD_READ, '0, 10'h000);
        wait_drained();
    endtask

    task automatic test_random_programs(input int n_progs);
        int len;
        for (int p = 0; p < n_progs; p++) begin
            send_cmd(CMD_CLEAR, 32'($urandom), 10'($urandom));
            len = $urandom_range(1, 24);
            for (int i = 0; i < len; i++) send_cmd(CMD_LOAD, gen_word(len), 10'($urandom));
            for (int i = 0; i < len; i++) begin
                case ($urandom_range(0, 15))
                    0:       send_cmd(CMD_READ, 32'($urandom), 10'($urandom));
                    1:       send_cmd(CMD_NOP, 32'($urandom), 10'($urandom));
                    2:       send_cmd(CMD_LOAD, gen_word(len), 10'($urandom));
                    default: send_cmd(CMD_READ, 32'($urandom), 10'($urandom_range(0, len)));
                endcase
            end
            if (p % 10 == 9) wait_drained();
        end
    endtask

    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready <= 1'b0;
        end else if (idle_en && $urandom_range(0, 9) == 0) begin
            stall_left <= $urandom_range(0, 16);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        rvc_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: word %h short %b status %0d",
                             m_data.out_word, m_data.is_compressed, m_data.status);
            end else begin
                want = expected_q.pop_front();
                if (m_data !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected word %h short %b status %0d, got %h %b %0d",
                                 want.out_word, want.is_compressed, want.status,
                                 m_data.out_word, m_data.is_compressed, m_data.status);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("timeout with %0d results outstanding", expected_q.size());
            $display("rv32i_to_rvc_compressor verification failed");
            $finish;
        end
    end

    initial begin
        prog_len = 0;
        addr_sums[0] = '0;
        mismatches = 0;
        reads_sent = 0;
        short_reads = 0;
        target_errs = 0;
        stall_left = 0;
        quiet_cycles = 0;
        idle_en = 1'b1;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_full_program();
        test_random_programs(20);
        idle_en = 1'b0;
        test_random_programs(10);
        wait_drained();
        repeat (20) @(posedge aclk);
        $display("covered %0d reads, %0d of them compressed, %0d with targets out of range",
                 reads_sent, short_reads, target_errs);
        $display("including a full program and random programs under random idling");
        if (mismatches == 0 && expected_q.size() == 0)
            $display("rv32i_to_rvc_compressor verification clean");
        else
            $display("rv32i_to_rvc_compressor verification failed");
        $finish;
    end

endmodule
